[hw/rtl/kalman_angle_bias_filter_assert.svh]
// assertion macros for the kalman angle/bias filter
`ifndef KALMAN_ANGLE_BIAS_FILTER_ASSERT_SVH
`define KALMAN_ANGLE_BIAS_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define KABF_ASSERT_IMP(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("kabf assertion failed");
`define KABF_ASSERT_NXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("kabf assertion failed");
`else
`define KABF_ASSERT_IMP(lbl, cond, prop)
`define KABF_ASSERT_NXT(lbl, cond, prop)
`endif
`endif

[hw/rtl/kabf_pkg.sv]
// shared types, codes and constants for the kalman angle/bias filter
package kabf_pkg;

	localparam int FRAC = 28;

	localparam logic [30:0] RST_SAMPLE_PERIOD = 31'd2684355;
	localparam logic [30:0] RST_ANGLE_NOISE   = 31'd268435;
	localparam logic [30:0] RST_BIAS_NOISE    = 31'd805306;
	localparam logic [30:0] RST_MEAS_NOISE    = 31'd8053064;

	localparam logic [1:0] CFG_SAMPLE_PERIOD = 2'd0;
	localparam logic [1:0] CFG_ANGLE_NOISE   = 2'd1;
	localparam logic [1:0] CFG_BIAS_NOISE    = 2'd2;
	localparam logic [1:0] CFG_MEAS_NOISE    = 2'd3;

	typedef logic [3:0] step_t;

	localparam step_t ST_PRED_ANG  = 4'd0;
	localparam step_t ST_DTP11     = 4'd1;
	localparam step_t ST_INNER     = 4'd2;
	localparam step_t ST_P00       = 4'd3;
	localparam step_t ST_P01P10    = 4'd4;
	localparam step_t ST_P11       = 4'd5;
	localparam step_t ST_INNOV     = 4'd6;
	localparam step_t ST_K0        = 4'd7;
	localparam step_t ST_K1        = 4'd8;
	localparam step_t ST_CORR_ANG  = 4'd9;
	localparam step_t ST_CORR_BIAS = 4'd10;
	localparam step_t ST_N00       = 4'd11;
	localparam step_t ST_N01       = 4'd12;
	localparam step_t ST_P10U      = 4'd13;
	localparam step_t ST_P11U      = 4'd14;
	localparam step_t ST_FINISH    = 4'd15;

	localparam logic [1:0] KIND_ALU = 2'd0;
	localparam logic [1:0] KIND_MUL = 2'd1;
	localparam logic [1:0] KIND_DIV = 2'd2;

	typedef struct packed {
		logic  load;
		logic  start;
		logic  commit;
		step_t step;
	} kabf_cmd_t;

	typedef struct packed {
		logic unit_done;
		logic s_pos;
		logic out_full;
	} kabf_sts_t;

	function automatic logic [1:0] step_kind(input step_t s);
		logic [1:0] k;
		case (s)
			ST_INNER, ST_P01P10, ST_INNOV, ST_FINISH: k = KIND_ALU;
			ST_K0, ST_K1: k = KIND_DIV;
			default: k = KIND_MUL;
		endcase
		return k;
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

endpackage

[hw/rtl/kabf_in_if.sv]
// request channel carrying one measurement pair
interface kabf_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] measured_angle;
	logic signed [31:0] measured_rate;

	modport source(output valid, output measured_angle, output measured_rate, input ready);
	modport sink(input valid, input measured_angle, input measured_rate, output ready);
endinterface

[hw/rtl/kabf_out_if.sv]
// result channel carrying the filtered estimates
interface kabf_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] angle_estimate;
	logic signed [31:0] bias_estimate;
	logic               saturated;

	modport source(output valid, output angle_estimate, output bias_estimate,
		output saturated, input ready);
	modport sink(input valid, input angle_estimate, input bias_estimate,
		input saturated, output ready);
endinterface

[hw/rtl/kabf_mul.sv]
// iterative signed multiplier, four bits a cycle, rounded q28 result capped at 2^62
module kabf_mul import kabf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic               done,
	output logic signed [63:0] res
);
	localparam int DIGITS = 16;

	logic [63:0]  x_q;
	logic [63:0]  y_q;
	logic         neg_q;
	logic [127:0] acc_q;
	logic [3:0]   cnt_q;
	logic         busy_q;
	logic         rnd_q;
	logic         done_q;
	logic signed [63:0] res_q;

	logic [67:0]  part;
	logic [127:0] rnd_sum;
	logic [99:0]  shifted;
	logic [63:0]  mag_r;

	assign part    = x_q * y_q[63:60];
	assign rnd_sum = acc_q + (128'd1 << (FRAC - 1));
	assign shifted = rnd_sum[127:FRAC];
	assign mag_r   = (shifted > (100'd1 << 62)) ? (64'd1 << 62) : shifted[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= rnd_q;
			rnd_q  <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(DIGITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= mag64(a);
			y_q   <= mag64(b);
			neg_q <= a[63] ^ b[63];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q << 4) + 128'(part);
			y_q   <= y_q << 4;
		end
		if (rnd_q) begin
			res_q <= neg_q ? -$signed(mag_r) : $signed(mag_r);
		end
	end

	assign done = done_q;
	assign res  = res_q;
endmodule

[hw/rtl/kabf_div.sv]
// restoring divider, one quotient bit a cycle, q28 result rounded half away from zero
module kabf_div import kabf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] n,
	input  logic signed [63:0] d,
	output logic               done,
	output logic signed [63:0] res
);
	localparam int NB = 64 + FRAC + 1;
	localparam int CW = $clog2(NB + 1);

	logic [63:0]    rem_q;
	logic [NB-1:0]  num_q;
	logic [63:0]    d_q;
	logic           neg_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           fin_q;
	logic           done_q;
	logic signed [63:0] res_q;

	logic [64:0] trial;
	logic [64:0] diff;
	logic        ge;
	logic [63:0] intp;
	logic [63:0] capped;
	logic [63:0] q;
	logic [63:0] qr;

	assign trial  = {rem_q, num_q[NB-1]};
	assign diff   = trial - {1'b0, d_q};
	assign ge     = trial >= {1'b0, d_q};
	// integer part is held at 2^33, fraction bits stay as found
	assign intp   = num_q[NB-1:FRAC+1];
	assign capped = (intp > (64'd1 << 33)) ? (64'd1 << 33) : intp;
	assign q      = {1'b0, capped[33:0], num_q[FRAC:0]};
	assign qr     = (q + 64'd1) >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NB - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= {mag64(n), {(FRAC + 1){1'b0}}};
			d_q   <= d;
			neg_q <= n[63];
		end else if (busy_q) begin
			rem_q <= ge ? diff[63:0] : trial[63:0];
			num_q <= {num_q[NB-2:0], ge};
		end
		if (fin_q) begin
			res_q <= neg_q ? -$signed(qr) : $signed(qr);
		end
	end

	assign done = done_q;
	assign res  = res_q;
endmodule

[hw/rtl/kabf_dp.sv]
// datapath: settings, filter state, temporaries, shared multiplier and divider, result register
module kabf_dp import kabf_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  kabf_cmd_t          cmd,
	output kabf_sts_t          sts,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic signed [31:0] measured_angle,
	input  logic signed [31:0] measured_rate,
	output logic signed [31:0] angle_estimate,
	output logic signed [31:0] bias_estimate,
	output logic               saturated,
	output logic               out_valid,
	input  logic               out_ready
);
	localparam logic signed [63:0] HI_W  = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] LO_W  = -HI_W - 64'sd1;
	localparam logic signed [63:0] HI_32 = 64'sd2147483647;
	localparam logic signed [63:0] LO_32 = -64'sd2147483648;

	function automatic logic signed [63:0] sat(input logic signed [63:0] v,
		input logic signed [63:0] hi, input logic signed [63:0] lo);
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	function automatic logic ovf(input logic signed [63:0] v,
		input logic signed [63:0] hi, input logic signed [63:0] lo);
		return (v > hi) || (v < lo);
	endfunction

	function automatic logic signed [63:0] sx(input logic signed [DATA_WIDTH-1:0] v);
		return 64'(v);
	endfunction

	localparam logic signed [63:0] P_INIT = sat(64'sd268435456, HI_W, LO_W);

	logic [30:0] dt_q, qa_q, qb_q, r_q;
	logic signed [DATA_WIDTH-1:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [DATA_WIDTH-1:0] k0_q, k1_q;
	logic flag_q;
	logic signed [31:0] meas_q, rate_q;
	logic signed [63:0] dtp11_q, inner_q, y_q, s_q, n00_q, n01_q;
	logic signed [31:0] ang_out_q, bias_out_q;
	logic sat_out_q, out_valid_q;

	logic signed [63:0] dt64, qa64, qb64, r64;
	logic signed [63:0] mul_a, mul_b, div_n, mul_res, div_res;
	logic mul_done, div_done;
	logic signed [63:0] ang_m, bias_m, p00_m, p11_add, p11_sub, p10_m, n00_v, n01_v;
	logic signed [63:0] p01_d, p10_d, inner_v, y_v, s_v;
	logic [1:0] kind;

	assign dt64 = {33'b0, dt_q};
	assign qa64 = {33'b0, qa_q};
	assign qb64 = {33'b0, qb_q};
	assign r64  = {33'b0, r_q};
	assign kind = step_kind(cmd.step);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_n = '0;
		case (cmd.step)
			ST_PRED_ANG: begin
				mul_a = dt64;
				mul_b = 64'(rate_q) - sx(bias_q);
			end
			ST_DTP11: begin
				mul_a = dt64;
				mul_b = sx(p11_q);
			end
			ST_P00: begin
				mul_a = dt64;
				mul_b = inner_q;
			end
			ST_P11: begin
				mul_a = qb64;
				mul_b = dt64;
			end
			ST_K0: div_n = sx(p00_q);
			ST_K1: div_n = sx(p10_q);
			ST_CORR_ANG: begin
				mul_a = sx(k0_q);
				mul_b = y_q;
			end
			ST_CORR_BIAS: begin
				mul_a = sx(k1_q);
				mul_b = y_q;
			end
			ST_N00: begin
				mul_a = sx(k0_q);
				mul_b = sx(p00_q);
			end
			ST_N01: begin
				mul_a = sx(k0_q);
				mul_b = sx(p01_q);
			end
			ST_P10U: begin
				mul_a = sx(k1_q);
				mul_b = sx(p00_q);
			end
			ST_P11U: begin
				mul_a = sx(k1_q);
				mul_b = sx(p01_q);
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	kabf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start && (kind == KIND_MUL)),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.res    (mul_res)
	);

	kabf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start && (kind == KIND_DIV)),
		.n      (div_n),
		.d      (s_q),
		.done   (div_done),
		.res    (div_res)
	);

	assign ang_m   = sx(ang_q) + mul_res;
	assign bias_m  = sx(bias_q) + mul_res;
	assign p00_m   = sx(p00_q) + mul_res;
	assign p11_add = sx(p11_q) + mul_res;
	assign p11_sub = sx(p11_q) - mul_res;
	assign p10_m   = sx(p10_q) - mul_res;
	assign n00_v   = sx(p00_q) - mul_res;
	assign n01_v   = sx(p01_q) - mul_res;
	assign p01_d   = sx(p01_q) - dtp11_q;
	assign p10_d   = sx(p10_q) - dtp11_q;
	assign inner_v = dtp11_q - sx(p01_q) - sx(p10_q) + qa64;
	assign y_v     = 64'(meas_q) - sx(ang_q);
	assign s_v     = sx(p00_q) + r64;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q        <= RST_SAMPLE_PERIOD;
			qa_q        <= RST_ANGLE_NOISE;
			qb_q        <= RST_BIAS_NOISE;
			r_q         <= RST_MEAS_NOISE;
			ang_q       <= '0;
			bias_q      <= '0;
			p00_q       <= DATA_WIDTH'(P_INIT);
			p01_q       <= '0;
			p10_q       <= '0;
			p11_q       <= DATA_WIDTH'(P_INIT);
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SAMPLE_PERIOD: dt_q <= cfg_data;
					CFG_ANGLE_NOISE:   qa_q <= cfg_data;
					CFG_BIAS_NOISE:    qb_q <= cfg_data;
					CFG_MEAS_NOISE:    r_q  <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load) begin
				flag_q <= 1'b0;
			end
			if (cmd.commit) begin
				case (cmd.step)
					ST_PRED_ANG, ST_CORR_ANG: begin
						ang_q  <= DATA_WIDTH'(sat(ang_m, HI_W, LO_W));
						flag_q <= flag_q | ovf(ang_m, HI_W, LO_W);
					end
					ST_CORR_BIAS: begin
						bias_q <= DATA_WIDTH'(sat(bias_m, HI_W, LO_W));
						flag_q <= flag_q | ovf(bias_m, HI_W, LO_W);
					end
					ST_P00: begin
						p00_q  <= DATA_WIDTH'(sat(p00_m, HI_W, LO_W));
						flag_q <= flag_q | ovf(p00_m, HI_W, LO_W);
					end
					ST_P01P10: begin
						p01_q  <= DATA_WIDTH'(sat(p01_d, HI_W, LO_W));
						p10_q  <= DATA_WIDTH'(sat(p10_d, HI_W, LO_W));
						flag_q <= flag_q | ovf(p01_d, HI_W, LO_W) | ovf(p10_d, HI_W, LO_W);
					end
					ST_P11: begin
						p11_q  <= DATA_WIDTH'(sat(p11_add, HI_W, LO_W));
						flag_q <= flag_q | ovf(p11_add, HI_W, LO_W);
					end
					ST_INNOV: begin
						if (!(s_v > 64'sd0)) begin
							flag_q <= 1'b1;
						end
					end
					ST_K0, ST_K1: begin
						flag_q <= flag_q | ovf(div_res, HI_W, LO_W);
					end
					ST_P10U: begin
						p10_q  <= DATA_WIDTH'(sat(p10_m, HI_W, LO_W));
						flag_q <= flag_q | ovf(p10_m, HI_W, LO_W);
					end
					ST_P11U: begin
						p11_q  <= DATA_WIDTH'(sat(p11_sub, HI_W, LO_W));
						flag_q <= flag_q | ovf(p11_sub, HI_W, LO_W);
					end
					ST_FINISH: begin
						p00_q       <= DATA_WIDTH'(sat(n00_q, HI_W, LO_W));
						p01_q       <= DATA_WIDTH'(sat(n01_q, HI_W, LO_W));
						out_valid_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			meas_q <= measured_angle;
			rate_q <= measured_rate;
		end
		if (cmd.commit) begin
			case (cmd.step)
				ST_DTP11: dtp11_q <= mul_res;
				ST_INNER: inner_q <= inner_v;
				ST_INNOV: begin
					y_q  <= y_v;
					s_q  <= s_v;
					// no correction when the innovation variance is not positive
					k0_q <= '0;
					k1_q <= '0;
				end
				ST_K0: k0_q <= DATA_WIDTH'(sat(div_res, HI_W, LO_W));
				ST_K1: k1_q <= DATA_WIDTH'(sat(div_res, HI_W, LO_W));
				ST_N00: n00_q <= n00_v;
				ST_N01: n01_q <= n01_v;
				ST_FINISH: begin
					ang_out_q  <= 32'(sat(sx(ang_q), HI_32, LO_32));
					bias_out_q <= 32'(sat(sx(bias_q), HI_32, LO_32));
					sat_out_q  <= flag_q | ovf(n00_q, HI_W, LO_W) | ovf(n01_q, HI_W, LO_W)
						| ovf(sx(ang_q), HI_32, LO_32) | ovf(sx(bias_q), HI_32, LO_32);
				end
				default: ;
			endcase
		end
	end

	assign sts.unit_done = mul_done | div_done;
	assign sts.s_pos     = s_q > 64'sd0;
	assign sts.out_full  = out_valid_q & ~out_ready;

	assign angle_estimate = ang_out_q;
	assign bias_estimate  = bias_out_q;
	assign saturated      = sat_out_q;
	assign out_valid      = out_valid_q;
endmodule

[hw/rtl/kabf_ctrl.sv]
// controller: walks the predict/correct step sequence and drives the datapath
module kabf_ctrl import kabf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  kabf_sts_t sts,
	output kabf_cmd_t cmd
);
	localparam logic [1:0] CS_IDLE  = 2'd0;
	localparam logic [1:0] CS_ISSUE = 2'd1;
	localparam logic [1:0] CS_WAIT  = 2'd2;

	logic [1:0] state_q, state_d;
	step_t      step_q, step_d;

	always_comb begin
		state_d    = state_q;
		step_d     = step_q;
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.start  = 1'b0;
		cmd.commit = 1'b0;
		cmd.step   = step_q;
		case (state_q)
			CS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					step_d   = ST_PRED_ANG;
					state_d  = CS_ISSUE;
				end
			end
			CS_ISSUE: begin
				if (step_q == ST_K0 && !sts.s_pos) begin
					step_d = ST_CORR_ANG;
				end else if (step_kind(step_q) == KIND_ALU) begin
					if (step_q == ST_FINISH) begin
						// hold until the result register has room
						if (!sts.out_full) begin
							cmd.commit = 1'b1;
							state_d    = CS_IDLE;
						end
					end else begin
						cmd.commit = 1'b1;
						step_d     = step_q + 4'd1;
					end
				end else begin
					cmd.start = 1'b1;
					state_d   = CS_WAIT;
				end
			end
			CS_WAIT: begin
				if (sts.unit_done) begin
					cmd.commit = 1'b1;
					step_d     = step_q + 4'd1;
					state_d    = CS_ISSUE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			step_q  <= ST_PRED_ANG;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end
endmodule

[hw/rtl/kalman_angle_bias_filter.sv]
// top level of the two-state angle/bias kalman filter
//
// in_ch takes one request per measurement: measured_angle and measured_rate,
// signed q16.16. out_ch returns one result per request: angle_estimate,
// bias_estimate (q16.16) and saturated, set on any clip or skipped gains.
// cfg_we/cfg_index/cfg_data write sample_period, angle_process_noise,
// bias_process_noise and measurement_noise (indexes 0 to 3, unsigned q3.28);
// write them only while no request is in flight.
// an update runs ten products on one shared 64x4-bit iterative multiplier and
// two gains on one restoring divider; when P00 plus R is not positive the
// divides are skipped. in_ch.ready is high only while no update is running,
// so one request is worked at a time. the result sits in an output register;
// a stalled receiver does not block the next request, but the following
// result waits until that register frees. reset clears angle and bias, sets
// P00 and P11 to one, P01 and P10 to zero and loads the default settings.
`include "kalman_angle_bias_filter_assert.svh"
module kalman_angle_bias_filter import kabf_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	kabf_in_if.sink     in_ch,
	kabf_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data
);
	kabf_cmd_t cmd;
	kabf_sts_t sts;

	kabf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kabf_dp #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.measured_angle (in_ch.measured_angle),
		.measured_rate  (in_ch.measured_rate),
		.angle_estimate (out_ch.angle_estimate),
		.bias_estimate  (out_ch.bias_estimate),
		.saturated      (out_ch.saturated),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready)
	);

	`KABF_ASSERT_NXT(a_busy_after_req, in_ch.valid && in_ch.ready, !in_ch.ready)
	`KABF_ASSERT_NXT(a_finish_gives_result, cmd.commit && cmd.step == ST_FINISH, out_ch.valid)
	`KABF_ASSERT_IMP(a_load_alone, cmd.load, !cmd.commit && !cmd.start)
endmodule

[tb/tb_top.sv]
// self-checking testbench for the two-state angle/bias kalman filter
module tb_top import kabf_pkg::*;;

	localparam int DW = 32;
	localparam int SETTLE = 500;
	localparam longint LIMIT = 6000000;

	typedef struct {
		logic signed [31:0] angle;
		logic signed [31:0] bias;
		logic               sat;
	} estimate_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [30:0] cfg_data;

	kabf_in_if  in_ch();
	kabf_out_if out_ch();

	kalman_angle_bias_filter #(.DATA_WIDTH(DW)) u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// filter model state and settings
	logic signed [63:0] dt, q_angle, q_bias, r_meas;
	logic signed [63:0] x_angle, x_bias, p00, p01, p10, p11;
	logic               step_sat;

	estimate_t pending_est[$];
	int     errors, n_sent, n_checked, n_sat;
	longint cycles;
	bit     no_idle, no_stall;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [63:0] clip(input logic signed [63:0] v, input int bits);
		logic signed [63:0] hi, lo;
		hi = (64'sd1 <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			step_sat = 1'b1;
			return hi;
		end
		if (v < lo) begin
			step_sat = 1'b1;
			return lo;
		end
		return v;
	endfunction

	// (a*b) >> 28, rounded half away from zero, magnitude held at 2^62
	function automatic logic signed [63:0] qmul(input logic signed [63:0] a, b);
		logic [63:0]  x, y;
		logic [127:0] p;
		logic         neg;
		logic signed [63:0] r;
		neg = (a < 0) != (b < 0);
		x = (a < 0) ? -a : a;
		y = (b < 0) ? -b : b;
		p = 128'(x) * 128'(y) + (128'd1 << (FRAC - 1));
		p = p >> FRAC;
		if (p > (128'd1 << 62))
			p = 128'd1 << 62;
		r = p[63:0];
		return neg ? -r : r;
	endfunction

	function automatic logic signed [63:0] qdiv(input logic signed [63:0] n, d);
		logic [63:0] un, ud, q, r;
		un = (n < 0) ? -n : n;
		ud = d;
		q = un / ud;
		r = un % ud;
		if (q > (64'd1 << 33))
			q = 64'd1 << 33;
		for (int i = 0; i <= FRAC; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= ud) begin
				r = r - ud;
				q = q | 64'd1;
			end
		end
		q = (q + 64'd1) >> 1;
		return (n < 0) ? -$signed(q) : $signed(q);
	endfunction

	function automatic estimate_t filter_update(input logic signed [31:0] m_angle, m_rate);
		logic signed [63:0] dtp11, inner, y, s, k0, k1, n00, n01, n10, n11;
		estimate_t e;
		step_sat = 1'b0;
		k0 = 0;
		k1 = 0;
		// predict
		x_angle = clip(x_angle + qmul(dt, 64'(m_rate) - x_bias), DW);
		dtp11 = qmul(dt, p11);
		inner = dtp11 - p01 - p10 + q_angle;
		p00 = clip(p00 + qmul(dt, inner), DW);
		p01 = clip(p01 - dtp11, DW);
		p10 = clip(p10 - dtp11, DW);
		p11 = clip(p11 + qmul(q_bias, dt), DW);
		// correct, using predicted p00/p01 throughout
		y = 64'(m_angle) - x_angle;
		s = p00 + r_meas;
		if (s > 0) begin
			k0 = clip(qdiv(p00, s), DW);
			k1 = clip(qdiv(p10, s), DW);
		end else begin
			step_sat = 1'b1;
		end
		x_angle = clip(x_angle + qmul(k0, y), DW);
		x_bias = clip(x_bias + qmul(k1, y), DW);
		n00 = p00 - qmul(k0, p00);
		n01 = p01 - qmul(k0, p01);
		n10 = p10 - qmul(k1, p00);
		n11 = p11 - qmul(k1, p01);
		p00 = clip(n00, DW);
		p01 = clip(n01, DW);
		p10 = clip(n10, DW);
		p11 = clip(n11, DW);
		e.angle = 32'(clip(x_angle, 32));
		e.bias = 32'(clip(x_bias, 32));
		e.sat = step_sat;
		return e;
	endfunction

	// result checker and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		estimate_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= no_stall || ($urandom_range(0, 99) >= 9);
			if (out_ch.valid && out_ch.ready) begin
				if (pending_est.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					e = pending_est.pop_front();
					n_checked++;
					if (e.sat)
						n_sat++;
					if (out_ch.angle_estimate !== e.angle) begin
						$error("angle_estimate expected %0d got %0d", e.angle,
							out_ch.angle_estimate);
						errors++;
					end
					if (out_ch.bias_estimate !== e.bias) begin
						$error("bias_estimate expected %0d got %0d", e.bias,
							out_ch.bias_estimate);
						errors++;
					end
					if (out_ch.saturated !== e.sat) begin
						$error("saturated expected %0b got %0b", e.sat, out_ch.saturated);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_request(input logic signed [31:0] m_angle, m_rate);
		if (!no_idle && $urandom_range(0, 99) < 9) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.measured_angle <= m_angle;
		in_ch.measured_rate <= m_rate;
		do
			@(posedge clk);
		while (!in_ch.ready);
		pending_est.push_back(filter_update(m_angle, m_rate));
		n_sent++;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_est.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_SAMPLE_PERIOD: dt = 64'(val);
			CFG_ANGLE_NOISE:   q_angle = 64'(val);
			CFG_BIAS_NOISE:    q_bias = 64'(val);
			CFG_MEAS_NOISE:    r_meas = 64'(val);
			default: ;
		endcase
	endtask

	task automatic set_all(input logic [30:0] per, qa, qb, rm);
		drain();
		write_reg(CFG_SAMPLE_PERIOD, per);
		write_reg(CFG_ANGLE_NOISE, qa);
		write_reg(CFG_BIAS_NOISE, qb);
		write_reg(CFG_MEAS_NOISE, rm);
	endtask

	function automatic logic signed [31:0] plausible_angle();
		// within about +/-180 degrees
		return $signed(32'($urandom_range(0, 23592960))) - 32'sd11796480;
	endfunction

	task automatic test_defaults();
		send_request(0, 0);
		send_request(32'sh7fffffff, 32'sh7fffffff);
		send_request(32'sh80000000, 32'sh80000000);
		send_request(32'sh7fffffff, 32'sh80000000);
		send_request(32'sh80000000, 32'sh7fffffff);
		send_request(-1, 1);
		send_request(32'sd65536 * 30, -32'sd65536 * 5);
		send_request(32'sd65536 * 30, -32'sd65536 * 5);
	endtask

	task automatic test_extreme_settings();
		// huge period and noise saturate the covariance
		set_all(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
		repeat (4) send_request(32'sh7fffffff, 32'sh80000000);
		// zero period with smallest noise: covariance can collapse
		set_all(31'd0, 31'd0, 31'd0, 31'd1);
		repeat (4) send_request(plausible_angle(), 0);
		// large period, tiny noise drives P00 negative so the gain is skipped
		set_all(31'h7fffffff, 31'd0, 31'd0, 31'd1);
		repeat (5) send_request(32'sh80000000, 32'sh7fffffff);
	endtask

	task automatic test_random();
		logic [30:0] per, qa, qb, rm;
		logic signed [31:0] true_ang, rate;
		for (int blk = 0; blk < 12; blk++) begin
			case ($urandom_range(0, 4))
				0: set_all(RST_SAMPLE_PERIOD, RST_ANGLE_NOISE, RST_BIAS_NOISE, RST_MEAS_NOISE);
				1: set_all(31'($urandom), 31'($urandom), 31'($urandom),
					31'($urandom_range(1, 32'h7fffffff)));
				default: begin
					per = 31'($urandom_range(268435, 26843545));
					qa = 31'($urandom_range(0, 2684354));
					qb = 31'($urandom_range(0, 2684354));
					rm = 31'($urandom_range(1, 26843545));
					set_all(per, qa, qb, rm);
				end
			endcase
			no_idle = (blk == 5);
			no_stall = (blk == 5);
			true_ang = plausible_angle();
			for (int i = 0; i < 150; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					send_request($signed($urandom), $signed($urandom));
				end else begin
					rate = $signed(32'($urandom_range(0, 26214400))) - 32'sd13107200;
					true_ang = true_ang + (rate >>> 7);
					send_request(true_ang + $signed(32'($urandom_range(0, 131072))) - 65536,
						rate + $signed(32'($urandom_range(0, 65536))));
				end
				if (i == 75 && blk == 3)
					drain();
			end
		end
		no_idle = 1'b0;
		no_stall = 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SAMPLE_PERIOD;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.measured_angle = '0;
		in_ch.measured_rate = '0;
		dt = 64'(RST_SAMPLE_PERIOD);
		q_angle = 64'(RST_ANGLE_NOISE);
		q_bias = 64'(RST_BIAS_NOISE);
		r_meas = 64'(RST_MEAS_NOISE);
		x_angle = 0;
		x_bias = 0;
		step_sat = 1'b0;
		p00 = clip(64'sd268435456, DW);
		p01 = 0;
		p10 = 0;
		p11 = clip(64'sd268435456, DW);
		errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_sat = 0;
		cycles = 0;
		no_idle = 1'b0;
		no_stall = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_extreme_settings();
		test_random();
		drain();
		$display("sent %0d measurements, checked %0d estimates, %0d with saturation",
			n_sent, n_checked, n_sat);
		$display("settings covered defaults, extremes and random periods and noise");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
